// ===== design/sorted_priority_queue_assert.svh =====
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq check failed");

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq check failed");

`endif

// ===== design/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;
    localparam int COUNT_BITS  = 5;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_CHG   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_RAISED    = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_DEQ,
        CH_REMOVE
    } chain_op_t;

    typedef enum logic {
        S_IDLE,
        S_INSERT
    } state_t;

endpackage

// ===== design/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts with its neighbors.
module spq_cell #(
    parameter int KEY_BITS  = 16,
    parameter int PRIO_BITS = 16
) (
    input  logic                        clk,
    input  spq_pkg::chain_op_t          op,
    input  logic [KEY_BITS-1:0]         new_key,
    input  logic signed [PRIO_BITS-1:0] new_prio,
    input  logic                        occupied,
    input  logic [KEY_BITS-1:0]         left_key,
    input  logic signed [PRIO_BITS-1:0] left_prio,
    input  logic                        left_place,
    input  logic                        left_hit,
    input  logic [KEY_BITS-1:0]         right_key,
    input  logic signed [PRIO_BITS-1:0] right_prio,
    output logic [KEY_BITS-1:0]         key,
    output logic signed [PRIO_BITS-1:0] prio,
    output logic                        place,
    output logic                        hit,
    output logic                        first_raise,
    output logic [KEY_BITS-1:0]         next_key,
    output logic signed [PRIO_BITS-1:0] next_prio
);
    import spq_pkg::*;

    logic [KEY_BITS-1:0]         key_reg;
    logic signed [PRIO_BITS-1:0] prio_reg;
    logic                        after;
    logic                        match;

    // entry sorts strictly after the broadcast item
    assign after = (prio_reg > new_prio) || ((prio_reg == new_prio) && (key_reg > new_key));
    assign place = !occupied || after;
    assign match = occupied && (key_reg == new_key);
    assign hit   = left_hit || match;
    assign first_raise = match && !left_hit && (new_prio > prio_reg);

    always_comb
    begin
        next_key  = key_reg;
        next_prio = prio_reg;
        case (op)
            CH_INSERT:
            begin
                if (left_place)
                begin
                    next_key  = left_key;
                    next_prio = left_prio;
                end
                else if (place)
                begin
                    next_key  = new_key;
                    next_prio = new_prio;
                end
            end
            CH_DEQ:
            begin
                next_key  = right_key;
                next_prio = right_prio;
            end
            CH_REMOVE:
            begin
                if (hit)
                begin
                    next_key  = right_key;
                    next_prio = right_prio;
                end
            end
            default:
            begin
                next_key  = key_reg;
                next_prio = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= next_key;
        prio_reg <= next_prio;
    end

    assign key  = key_reg;
    assign prio = prio_reg;

endmodule

// ===== design/spq_chain.sv =====
// Row of cells plus the found / raised reductions over it.
module spq_chain #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 16,
    parameter int PRIO_BITS   = 16,
    parameter int CNT_BITS    = 5
) (
    input  logic                        clk,
    input  spq_pkg::chain_op_t          op,
    input  logic [KEY_BITS-1:0]         new_key,
    input  logic signed [PRIO_BITS-1:0] new_prio,
    input  logic [CNT_BITS-1:0]         count,
    output logic [KEY_BITS-1:0]         head_key,
    output logic signed [PRIO_BITS-1:0] head_prio,
    output logic [KEY_BITS-1:0]         head_next_key,
    output logic signed [PRIO_BITS-1:0] head_next_prio,
    output logic                        found,
    output logic                        raised
);
    import spq_pkg::*;

    logic [KEY_BITS-1:0]         key_w      [QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0] prio_w     [QUEUE_DEPTH];
    logic [KEY_BITS-1:0]         nkey_w     [QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0] nprio_w    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]      place_w;
    logic [QUEUE_DEPTH-1:0]      hit_w;
    logic [QUEUE_DEPTH-1:0]      raise_w;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]         lkey;
        logic signed [PRIO_BITS-1:0] lprio;
        logic                        lplace;
        logic                        lhit;
        logic [KEY_BITS-1:0]         rkey;
        logic signed [PRIO_BITS-1:0] rprio;

        if (i == 0)
        begin : g_first
            assign lkey   = '0;
            assign lprio  = '0;
            assign lplace = 1'b0;
            assign lhit   = 1'b0;
        end
        else
        begin : g_mid
            assign lkey   = key_w[i-1];
            assign lprio  = prio_w[i-1];
            assign lplace = place_w[i-1];
            assign lhit   = hit_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign rkey  = '0;
            assign rprio = '0;
        end
        else
        begin : g_inner
            assign rkey  = key_w[i+1];
            assign rprio = prio_w[i+1];
        end

        spq_cell #(
            .KEY_BITS  (KEY_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk         (clk),
            .op          (op),
            .new_key     (new_key),
            .new_prio    (new_prio),
            .occupied    (CNT_BITS'(i) < count),
            .left_key    (lkey),
            .left_prio   (lprio),
            .left_place  (lplace),
            .left_hit    (lhit),
            .right_key   (rkey),
            .right_prio  (rprio),
            .key         (key_w[i]),
            .prio        (prio_w[i]),
            .place       (place_w[i]),
            .hit         (hit_w[i]),
            .first_raise (raise_w[i]),
            .next_key    (nkey_w[i]),
            .next_prio   (nprio_w[i])
        );
    end

    assign head_key       = key_w[0];
    assign head_prio      = prio_w[0];
    assign head_next_key  = nkey_w[0];
    assign head_next_prio = nprio_w[0];
    assign found          = hit_w[QUEUE_DEPTH-1];
    assign raised         = |raise_w;

endmodule

// ===== design/sorted_priority_queue.sv =====
// Top level: bounded min-priority queue kept sorted in a shifting chain of cells.
//
//  channel | handshake          | word fields
//  --------+--------------------+--------------------------------------------------
//  in      | in_valid/in_ready  | cmd, item_key, item_priority
//  out     | out_valid/out_ready| status, head_key, head_priority, head_valid,
//          |                    | entry_count
//
// Enqueue, dequeue, clear and any failing change are a single pass over the chain;
// a successful priority change makes two passes (remove, then insert).
// One word is in flight at a time; the result sits in an output register and
// the next word is taken while that result is being read.
// Reset clears the count and the control state only; cells past the count are
// never looked at, so entry storage needs no clearing.
// A stalled output holds off new input words.

`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 16,
    parameter int PRIO_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [spq_pkg::CMD_BITS-1:0]        cmd,
    input  logic [KEY_BITS-1:0]                 item_key,
    input  logic signed [PRIO_BITS-1:0]         item_priority,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [spq_pkg::STATUS_BITS-1:0]     status,
    output logic [KEY_BITS-1:0]                 head_key,
    output logic signed [PRIO_BITS-1:0]         head_priority,
    output logic                                head_valid,
    output logic [spq_pkg::COUNT_BITS-1:0]      entry_count
);
    import spq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    // word held across the two halves of a priority change
    logic [KEY_BITS-1:0]         pend_key_reg;
    logic signed [PRIO_BITS-1:0] pend_prio_reg;

    // result register
    status_t                     status_reg, status_next;
    logic [KEY_BITS-1:0]         hkey_reg, hkey_next;
    logic signed [PRIO_BITS-1:0] hprio_reg, hprio_next;
    logic                        hvalid_reg, hvalid_next;
    logic [CW-1:0]               ocount_reg;

    logic                        accept;
    logic                        load_out;
    logic                        deq_hit;
    chain_op_t                   op;
    logic [KEY_BITS-1:0]         bc_key;
    logic signed [PRIO_BITS-1:0] bc_prio;

    logic [KEY_BITS-1:0]         cur_key;
    logic signed [PRIO_BITS-1:0] cur_prio;
    logic [KEY_BITS-1:0]         nxt_key;
    logic signed [PRIO_BITS-1:0] nxt_prio;
    logic                        found;
    logic                        raised;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // second half of a change re-broadcasts the held word
    assign bc_key  = (state_reg == S_INSERT) ? pend_key_reg  : item_key;
    assign bc_prio = (state_reg == S_INSERT) ? pend_prio_reg : item_priority;

    spq_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .PRIO_BITS   (PRIO_BITS),
        .CNT_BITS    (CW)
    ) u_chain (
        .clk            (clk),
        .op             (op),
        .new_key        (bc_key),
        .new_prio       (bc_prio),
        .count          (count_reg),
        .head_key       (cur_key),
        .head_prio      (cur_prio),
        .head_next_key  (nxt_key),
        .head_next_prio (nxt_prio),
        .found          (found),
        .raised         (raised)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op          = CH_HOLD;
        load_out    = 1'b0;
        deq_hit     = 1'b0;
        status_next = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (cmd_t'(cmd))
                        CMD_ENQ:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                                status_next = ST_FULL;
                            else
                            begin
                                op         = CH_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                op         = CH_DEQ;
                                deq_hit    = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_CHG:
                        begin
                            if (!found)
                                status_next = ST_NOT_FOUND;
                            else if (raised)
                                status_next = ST_RAISED;
                            else
                            begin
                                // pull the entry out now, put it back next cycle
                                op         = CH_REMOVE;
                                count_next = count_reg - 1'b1;
                                load_out   = 1'b0;
                                state_next = S_INSERT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_INSERT:
            begin
                op         = CH_INSERT;
                count_next = count_reg + 1'b1;
                load_out   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // head after the command, or the removed head on a dequeue
        hvalid_next = deq_hit || (count_next != '0);
        if (deq_hit)
        begin
            hkey_next  = cur_key;
            hprio_next = cur_prio;
        end
        else if (hvalid_next)
        begin
            hkey_next  = nxt_key;
            hprio_next = nxt_prio;
        end
        else
        begin
            hkey_next  = '0;
            hprio_next = '0;
        end

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_key_reg  <= item_key;
            pend_prio_reg <= item_priority;
        end
        if (load_out)
        begin
            status_reg <= status_next;
            hkey_reg   <= hkey_next;
            hprio_reg  <= hprio_next;
            hvalid_reg <= hvalid_next;
            ocount_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign head_key      = hkey_reg;
    assign head_priority = hprio_reg;
    assign head_valid    = hvalid_reg;
    assign entry_count   = COUNT_BITS'(ocount_reg);

    // count stays within the chain
    `SPQ_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    // the insert half of a change starts with the result register empty
    `SPQ_ASSERT_NOW(a_insert_out_empty, state_reg == S_INSERT, !out_valid_reg)
    // the insert half always finishes with a result
    `SPQ_ASSERT_NEXT(a_insert_done, state_reg == S_INSERT, (state_reg == S_IDLE) && out_valid_reg)
    // an accepted enqueue with room grows the queue by one
    `SPQ_ASSERT_NEXT(a_enq_grows,
        accept && (cmd == CMD_ENQ) && (count_reg < CW'(QUEUE_DEPTH)),
        count_reg == CW'($past(count_reg) + 1'b1))

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: directed corner cases, then a random command mix.
module tb_top;
    import spq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int KEY_W        = 16;
    localparam int PRIO_W       = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_WORDS = 1320;

    typedef logic [KEY_W-1:0]         key_t;
    typedef logic signed [PRIO_W-1:0] prio_t;

    typedef struct {
        status_t               status;
        key_t                  key;
        prio_t                 prio;
        logic                  valid;
        logic [COUNT_BITS-1:0] count;
    } head_report_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic [CMD_BITS-1:0]    cmd           = '0;
    key_t                   item_key      = '0;
    prio_t                  item_priority = '0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic [STATUS_BITS-1:0] status;
    key_t                   head_key;
    prio_t                  head_priority;
    logic                   head_valid;
    logic [COUNT_BITS-1:0]  entry_count;

    // shadow copy of the sorted entries
    key_t  shadow_key [DEPTH];
    prio_t shadow_prio [DEPTH];
    int    shadow_count = 0;

    head_report_t pending_reports[$];
    head_report_t want_report;
    int           errors          = 0;
    int           words_sent      = 0;
    int           reports_checked = 0;
    int           status_tally[5] = '{default: 0};
    int           cycle_count     = 0;
    bit           steady_flow     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_priority_queue #(
        .QUEUE_DEPTH(DEPTH),
        .KEY_BITS   (KEY_W),
        .PRIO_BITS  (PRIO_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .item_key     (item_key),
        .item_priority(item_priority),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .head_key     (head_key),
        .head_priority(head_priority),
        .head_valid   (head_valid),
        .entry_count  (entry_count)
    );

    // ---------------- predictor ----------------

    function automatic bit sorts_after(int idx, prio_t p, key_t k);
        if (shadow_prio[idx] != p)
            return shadow_prio[idx] > p;
        return shadow_key[idx] > k;
    endfunction

    // equal entries stay ahead of the new one
    function automatic void shadow_insert(key_t k, prio_t p);
        int pos;
        pos = 0;
        while (pos < shadow_count && !sorts_after(pos, p, k))
            pos++;
        for (int i = shadow_count; i > pos; i--)
        begin
            shadow_key[i]  = shadow_key[i-1];
            shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_key[pos]  = k;
        shadow_prio[pos] = p;
        shadow_count++;
    endfunction

    function automatic void shadow_remove(int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
        begin
            shadow_key[i]  = shadow_key[i+1];
            shadow_prio[i] = shadow_prio[i+1];
        end
        shadow_count--;
    endfunction

    function automatic head_report_t queue_predict(cmd_t op, key_t k, prio_t p);
        head_report_t r;
        int           hit;
        r.status = ST_OK;
        r.key    = '0;
        r.prio   = '0;
        r.valid  = 1'b0;
        case (op)
            CMD_ENQ:
            begin
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                    shadow_insert(k, p);
            end
            CMD_DEQ:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.key   = shadow_key[0];
                    r.prio  = shadow_prio[0];
                    r.valid = 1'b1;
                    shadow_remove(0);
                end
            end
            CMD_CHG:
            begin
                // first matching key in queue order
                hit = -1;
                for (int i = 0; i < shadow_count && hit < 0; i++)
                    if (shadow_key[i] == k)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else if (p > shadow_prio[hit])
                    r.status = ST_RAISED;
                else
                begin
                    shadow_remove(hit);
                    shadow_insert(k, p);
                end
            end
            default:
                shadow_count = 0;
        endcase
        if (op != CMD_DEQ && shadow_count > 0)
        begin
            r.key   = shadow_key[0];
            r.prio  = shadow_prio[0];
            r.valid = 1'b1;
        end
        r.count = COUNT_BITS'(shadow_count);
        return r;
    endfunction

    // ---------------- driving ----------------

    always @(posedge clk)
        out_ready <= steady_flow || ($urandom_range(99) >= 12);

    task automatic send_word(cmd_t op, key_t k, prio_t p);
        int gap;
        gap = 0;
        if (!steady_flow)
            while ($urandom_range(99) < 12)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        item_key      <= k;
        item_priority <= p;
        do
            @(posedge clk);
        while (!in_ready);
        pending_reports.push_back(queue_predict(op, k, p));
        words_sent++;
    endtask

    function automatic key_t pick_key();
        if ($urandom_range(99) < 20)
            return key_t'($urandom);
        return key_t'($urandom_range(23));
    endfunction

    // mostly a narrow band so that ties are common
    function automatic prio_t pick_prio();
        int r;
        r = $urandom_range(99);
        if (r < 8)
        begin
            case ($urandom_range(3))
                0:       return prio_t'(-32768);
                1:       return prio_t'(32767);
                2:       return prio_t'(-1);
                default: return prio_t'(0);
            endcase
        end
        if (r < 25)
            return prio_t'($urandom);
        return prio_t'(int'($urandom_range(15)) - 8);
    endfunction

    // ---------------- checking ----------------

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word: expected none, actual status %0d",
                         $time, status);
            end
            else
            begin
                want_report = pending_reports.pop_front();
                compare_field("status", want_report.status, status);
                compare_field("head_key", want_report.key, head_key);
                compare_field("head_priority", want_report.prio, head_priority);
                compare_field("head_valid", want_report.valid, head_valid);
                compare_field("entry_count", want_report.count, entry_count);
                status_tally[want_report.status]++;
                reports_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_reports.size());
            $display("sorted_priority_queue regression: fail");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_empty_queue();
        send_word(CMD_DEQ, 16'h0000, prio_t'(0));
        send_word(CMD_CHG, 16'h1234, prio_t'(-5));
        send_word(CMD_CLEAR, 16'hFFFF, prio_t'(-1));
    endtask

    task automatic test_ordering_and_full();
        send_word(CMD_ENQ, 16'hFFFF, prio_t'(32767));
        send_word(CMD_ENQ, 16'h0000, prio_t'(-32768));
        send_word(CMD_ENQ, 16'd7, prio_t'(0));
        send_word(CMD_ENQ, 16'd3, prio_t'(0));
        send_word(CMD_ENQ, 16'd7, prio_t'(0));
        for (int i = 0; i < DEPTH - 5; i++)
            send_word(CMD_ENQ, key_t'($urandom_range(200, 100)), prio_t'($urandom_range(50, 1)));
        // one past capacity
        send_word(CMD_ENQ, 16'd1, prio_t'(1));
    endtask

    task automatic test_change_rules();
        send_word(CMD_CHG, 16'd7, prio_t'(0));            // equal: re-queued behind its twin
        send_word(CMD_CHG, 16'd3, prio_t'(5));            // raise refused
        send_word(CMD_CHG, 16'hABCD, prio_t'(0));         // absent key
        send_word(CMD_CHG, 16'hFFFF, prio_t'(-32768));    // lowest tie, lands after key 0
        send_word(CMD_DEQ, 16'h0000, prio_t'(0));
        send_word(CMD_DEQ, 16'h0000, prio_t'(0));
        send_word(CMD_CLEAR, 16'h0000, prio_t'(0));
    endtask

    task automatic test_random_mix(int n_words);
        int    r;
        int    bias;
        int    idx;
        int    lowered;
        cmd_t  op;
        key_t  k;
        prio_t p;
        for (int n = 0; n < n_words; n++)
        begin
            steady_flow = (n >= 500 && n < 800);
            // phases lean toward filling, draining, or a balance
            bias = (n / 60) % 3;
            r = $urandom_range(99);
            if (r < (bias == 0 ? 60 : (bias == 1 ? 20 : 40)))
                op = CMD_ENQ;
            else if (r < (bias == 0 ? 75 : (bias == 1 ? 70 : 65)))
                op = CMD_DEQ;
            else if (r < 98)
                op = CMD_CHG;
            else
                op = CMD_CLEAR;
            k = pick_key();
            p = pick_prio();
            if (op == CMD_CHG && shadow_count > 0 && $urandom_range(99) < 75)
            begin
                idx = $urandom_range(shadow_count - 1, 0);
                k   = shadow_key[idx];
                r   = $urandom_range(99);
                lowered = int'(shadow_prio[idx]) - int'($urandom_range(20, 0));
                if (r < 60)
                    p = (lowered < -32768) ? prio_t'(-32768) : prio_t'(lowered);
                else if (r < 75)
                    p = shadow_prio[idx];
            end
            send_word(op, k, p);
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_ordering_and_full();
        test_change_rules();
        test_random_mix(RANDOM_WORDS);
        in_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d command words, checked %0d result words", words_sent,
                 reports_checked);
        $display("outcomes: ok %0d, empty %0d, not found %0d, raised %0d, full %0d",
                 status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_NOT_FOUND],
                 status_tally[ST_RAISED], status_tally[ST_FULL]);
        if (errors == 0)
            $display("sorted_priority_queue regression: pass");
        else
            $display("sorted_priority_queue regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/spq_chain.sv
design/sorted_priority_queue.sv
dv/tb_top.sv
